// ===== src/stok_pkg.sv =====
package stok_pkg;

   // Position counter width and token length saturation point.
   localparam int POS_WIDTH     = 32;
   localparam int MAX_TOKEN_LEN = 255;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int EXT_W         = (LEN_W > 8) ? LEN_W : 8;

   // Result queue.
   localparam int QDEPTH = 4;
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int MAX_RSP = 3;

   // Token kinds.
   localparam logic [4:0] KIND_INT     = 5'd0;
   localparam logic [4:0] KIND_ID      = 5'd1;
   localparam logic [4:0] KIND_STMT    = 5'd2;
   localparam logic [4:0] KIND_STR     = 5'd3;
   localparam logic [4:0] KIND_EQ      = 5'd4;
   localparam logic [4:0] KIND_GT      = 5'd5;
   localparam logic [4:0] KIND_LT      = 5'd6;
   localparam logic [4:0] KIND_PLUS    = 5'd7;
   localparam logic [4:0] KIND_MINUS   = 5'd8;
   localparam logic [4:0] KIND_STAR    = 5'd9;
   localparam logic [4:0] KIND_SLASH   = 5'd10;
   localparam logic [4:0] KIND_NEWLINE = 5'd11;
   localparam logic [4:0] KIND_LPAREN  = 5'd12;
   localparam logic [4:0] KIND_RPAREN  = 5'd13;
   localparam logic [4:0] KIND_LBRACK  = 5'd14;
   localparam logic [4:0] KIND_RBRACK  = 5'd15;
   localparam logic [4:0] KIND_LBRACE  = 5'd16;
   localparam logic [4:0] KIND_RBRACE  = 5'd17;
   localparam logic [4:0] KIND_COMMA   = 5'd18;
   localparam logic [4:0] KIND_COLON   = 5'd19;
   localparam logic [4:0] KIND_EOF     = 5'd20;
   localparam logic [4:0] KIND_ERR     = 5'd21;
   localparam logic [4:0] KIND_NONE    = 5'd0;  // punct decode miss

   // Keyword codes.
   localparam logic [2:0] KW_NONE = 3'd0;
   localparam int         NUM_KW  = 5;

   // Special bytes.
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_HASH  = 8'd35;

   localparam logic [NUM_KW-1:0] KW_ALL = '1;

   // Keyword spellings, zero padded; row k is keyword code k+1.
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0},
      '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
      '{"f", "o", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0}
   };
   localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
      LEN_W'(6), LEN_W'(2), LEN_W'(4), LEN_W'(3), LEN_W'(5)
   };

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_ID,
      MODE_STR,
      MODE_COMMENT,
      MODE_HALT
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] start_pos;
      logic [7:0]  length;
      logic [2:0]  keyword;
      logic [7:0]  bad_char;
      logic        last;
   } rsp_type;

   // Results of one byte: count and up to three records, oldest in [0].
   typedef struct packed {
      logic [1:0]                 count;
      rsp_type [MAX_RSP-1:0]      recs;
   } lex_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "=":     k = KIND_EQ;
         ">":     k = KIND_GT;
         "<":     k = KIND_LT;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         CH_NL:   k = KIND_NEWLINE;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ":":     k = KIND_COLON;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Drop keyword candidates that do not have byte c at offset len.
   function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cand,
                                                   input logic [LEN_W-1:0]  len,
                                                   input logic [7:0]        c);
      logic [NUM_KW-1:0] r;
      r = cand;
      for (int k = 0; k < NUM_KW; k++) begin
         if (len >= KW_LEN[k]) begin
            r[k] = 1'b0;
         end else if (KW_TEXT[k][len[2:0]] != c) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] sat8(input logic [LEN_W-1:0] len);
      logic [EXT_W-1:0] e;
      e = EXT_W'(len);
      return (e > EXT_W'(255)) ? 8'hFF : e[7:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [4:0]           kind,
                                        input logic [POS_WIDTH-1:0] pos,
                                        input logic [LEN_W-1:0]     len,
                                        input logic [2:0]           kw,
                                        input logic [7:0]           bad);
      rsp_type r;
      r.kind      = kind;
      r.start_pos = 32'(pos);
      r.length    = sat8(len);
      r.keyword   = kw;
      r.bad_char  = bad;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

// ===== src/stok_lexer.sv =====
module stok_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  stok_pkg::req_type    item,
   output stok_pkg::lex_out_type lex
);
   import stok_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   start_ff, start_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [NUM_KW-1:0]      cand_ff, cand_in;

   logic [7:0]  c;
   logic        eoi;
   logic        dig, alp, ws, fresh;
   logic [4:0]  pk;
   logic [LEN_W-1:0] len_grow;
   logic [2:0]  kw_code;

   assign c        = item.ch;
   assign eoi      = item.end_of_input || (c == CH_NUL);
   assign dig      = is_digit(c);
   assign alp      = is_alpha(c);
   assign ws       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   assign pk       = punct_kind(c);
   assign len_grow = (len_ff < LEN_W'(MAX_TOKEN_LEN)) ? len_ff + LEN_W'(1) : len_ff;

   // byte that starts fresh: idle, or ends a number/identifier run
   always_comb begin
      case (mode_ff)
         MODE_NUM:     fresh = !dig;
         MODE_ID:      fresh = !(dig || alp);
         MODE_STR:     fresh = 1'b0;
         MODE_COMMENT: fresh = 1'b0;
         MODE_HALT:    fresh = 1'b0;
         default:      fresh = 1'b1;
      endcase
   end

   // first live keyword whose length matches the run
   always_comb begin
      kw_code = KW_NONE;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (cand_ff[k] && (len_ff == KW_LEN[k])) begin
            kw_code = 3'(k + 1);
         end
      end
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      cand_in  = cand_ff;
      if (eoi) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         cand_in  = KW_ALL;
      end else begin
         pos_in = pos_ff + POS_WIDTH'(1);
         case (mode_ff)
            MODE_NUM: begin
               if (dig) len_in = len_grow;
            end
            MODE_ID: begin
               if (dig || alp) begin
                  cand_in = kw_filter(cand_ff, len_ff, c);
                  len_in  = len_grow;
               end
            end
            MODE_STR: begin
               if (c == CH_QUOTE) mode_in = MODE_IDLE;
               else               len_in  = len_grow;
            end
            MODE_COMMENT: begin
               if (c == CH_NL) mode_in = MODE_IDLE;
            end
            default: ;
         endcase
         if (fresh) begin
            mode_in = MODE_IDLE;
            if (ws) begin
               mode_in = MODE_IDLE;
            end else if (dig) begin
               mode_in  = MODE_NUM;
               start_in = pos_ff;
               len_in   = LEN_W'(1);
            end else if (alp) begin
               mode_in  = MODE_ID;
               start_in = pos_ff;
               len_in   = LEN_W'(1);
               cand_in  = kw_filter(KW_ALL, '0, c);
            end else if (c == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (c == CH_QUOTE) begin
               mode_in  = MODE_STR;
               start_in = pos_ff + POS_WIDTH'(1);
               len_in   = '0;
            end else if (pk == KIND_NONE) begin
               mode_in = MODE_HALT;
            end
         end
      end
   end

   // result records
   always_comb begin
      logic [1:0] n;
      n    = 2'd0;
      lex  = '0;
      if (eoi) begin
         case (mode_ff)
            MODE_NUM: begin
               lex.recs[n] = make_rsp(KIND_INT, start_ff, len_ff, KW_NONE, 8'd0);
               n = n + 2'd1;
            end
            MODE_ID: begin
               lex.recs[n] = make_rsp((kw_code != KW_NONE) ? KIND_STMT : KIND_ID,
                                      start_ff, len_ff, kw_code, 8'd0);
               n = n + 2'd1;
            end
            MODE_STR: begin
               lex.recs[n] = make_rsp(KIND_ERR, start_ff, len_ff, KW_NONE, CH_QUOTE);
               n = n + 2'd1;
            end
            default: ;
         endcase
         lex.recs[n] = make_rsp(KIND_NEWLINE, pos_ff, LEN_W'(1), KW_NONE, 8'd0);
         n = n + 2'd1;
         lex.recs[n] = make_rsp(KIND_EOF, pos_ff, '0, KW_NONE, 8'd0);
         n = n + 2'd1;
      end else begin
         case (mode_ff)
            MODE_NUM: begin
               if (!dig) begin
                  lex.recs[n] = make_rsp(KIND_INT, start_ff, len_ff, KW_NONE, 8'd0);
                  n = n + 2'd1;
               end
            end
            MODE_ID: begin
               if (!(dig || alp)) begin
                  lex.recs[n] = make_rsp((kw_code != KW_NONE) ? KIND_STMT : KIND_ID,
                                         start_ff, len_ff, kw_code, 8'd0);
                  n = n + 2'd1;
               end
            end
            MODE_STR: begin
               if (c == CH_QUOTE) begin
                  lex.recs[n] = make_rsp(KIND_STR, start_ff, len_ff, KW_NONE, 8'd0);
                  n = n + 2'd1;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  lex.recs[n] = make_rsp(KIND_NEWLINE, pos_ff, LEN_W'(1), KW_NONE, 8'd0);
                  n = n + 2'd1;
               end
            end
            default: ;
         endcase
         if (fresh && !ws && !dig && !alp && (c != CH_HASH) && (c != CH_QUOTE)) begin
            if (pk != KIND_NONE) begin
               lex.recs[n] = make_rsp(pk, pos_ff, LEN_W'(1), KW_NONE, 8'd0);
            end else begin
               lex.recs[n] = make_rsp(KIND_ERR, pos_ff, LEN_W'(1), KW_NONE, c);
            end
            n = n + 2'd1;
         end
      end
      if (n != 2'd0) lex.recs[n - 2'd1].last = 1'b1;
      lex.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         cand_ff  <= KW_ALL;
      end else if (go) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         cand_ff  <= cand_in;
      end
   end

endmodule

// ===== src/stok_queue.sv =====
module stok_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  stok_pkg::lex_out_type        push,
   input  logic                         pop,
   output stok_pkg::rsp_type            head,
   output logic [stok_pkg::QCNT_W-1:0]  count
);
   import stok_pkg::*;

   rsp_type             q_ff [QDEPTH];
   rsp_type             q_in [QDEPTH];
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      logic [QCNT_W-1:0] base;
      q_in = q_ff;
      base = count_ff;
      if (pop) begin
         for (int i = 0; i < QDEPTH - 1; i++) q_in[i] = q_ff[i + 1];
         base = count_ff - QCNT_W'(1);
      end
      for (int j = 0; j < MAX_RSP; j++) begin
         if (2'(j) < push.count) begin
            q_in[$clog2(QDEPTH)'(base + QCNT_W'(j))] = push.recs[j];
         end
      end
      count_in = base + QCNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign head  = q_ff[0];
   assign count = count_ff;

endmodule

// ===== src/source_tokenizer.sv =====
// Channel   Dir  Handshake           Payload
// req_      in   req_valid/req_stall  req_data: byte and end marker
// rsp_      out  rsp_valid/rsp_stall  rsp_data: one token record
//
// One byte per cycle while the queue has room: a transaction lands in the input
// register, is lexed from there and its records enter a four-deep result queue,
// whose head drives rsp_. Every byte waits in the input register until the queue
// has room for three records; the queue drains one record per cycle while rsp_stall
// is low, so a byte that yields two or three records (run end, end marker) can
// stall the next one. Reset is synchronous and returns the lexer to idle at
// position zero with an empty queue.
// rsp_stall backs up the queue, which in turn stalls req_.
module source_tokenizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stok_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stok_pkg::rsp_type rsp_data
);
   import stok_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        req_take;
   logic        go;

   lex_out_type       lex;
   lex_out_type       push;
   logic              pop;
   logic [QCNT_W-1:0] q_count;

   // lex only when the queue can absorb a worst-case byte
   assign go        = in_valid_ff && (q_count <= QCNT_W'(QDEPTH - MAX_RSP));
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (go)   in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
      if (req_take) in_data_ff <= req_data;
   end

   stok_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (in_data_ff),
      .lex   (lex)
   );

   always_comb begin
      push       = lex;
      push.count = go ? lex.count : 2'd0;
   end

   assign rsp_valid = (q_count != '0);
   assign pop       = rsp_valid && !rsp_stall;

   stok_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (rsp_data),
      .count (q_count)
   );

   // ---------------------------------------------------------------- checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held byte lost");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (go && (in_data_ff.end_of_input || (in_data_ff.ch == CH_NUL)))
         |-> (lex.count >= 2'd2))
      else $error("end marker without newline and eof");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_EOF)) |-> rsp_data.last)
      else $error("eof record not marked last");

endmodule

// ===== tb/tb_source_tokenizer.sv =====
module tb_source_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import stok_pkg::*;

   // Quiet-cycle limit: the longest legal silence is the receiver hold-off
   // below plus a few random idle runs, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 120;
   localparam int SHOWN_FAILS = 10;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Lexer state mirrored by the token predictor.
   mode_type          lex_mode   = MODE_IDLE;
   logic [31:0]       lex_pos    = '0;
   logic [31:0]       tok_start  = '0;
   logic [7:0]        tok_len    = '0;
   logic [NUM_KW-1:0] kw_live    = KW_ALL;

   rsp_type due_tokens[$];   // tokens predicted but not yet seen

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int live_items    = 0;    // accepted transactions the lexer did not ignore
   int fail_count    = 0;
   int quiet_cycles  = 0;
   int hold_left     = 0;
   bit hold_pending  = 1'b0;

   source_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------

   function automatic string kw_word(input int k);
      case (k)
         0:       return "return";
         1:       return "if";
         2:       return "else";
         3:       return "for";
         default: return "while";
      endcase
   endfunction

   function automatic bit digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [4:0] punct_code(input logic [7:0] c);
      case (c)
         "=":     return KIND_EQ;
         ">":     return KIND_GT;
         "<":     return KIND_LT;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         CH_NL:   return KIND_NEWLINE;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         ",":     return KIND_COMMA;
         ":":     return KIND_COLON;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic void queue_token(input logic [4:0] kind, input logic [31:0] start,
                                       input logic [7:0] len, input logic [2:0] kw,
                                       input logic [7:0] bad);
      rsp_type t;
      t.kind      = kind;
      t.start_pos = start;
      t.length    = len;
      t.keyword   = kw;
      t.bad_char  = bad;
      t.last      = 1'b0;
      due_tokens.push_back(t);
   endfunction

   // A keyword stays live only while each new byte matches its spelling.
   function automatic void kw_track(input logic [7:0] c);
      string w;
      for (int k = 0; k < NUM_KW; k++) begin
         w = kw_word(k);
         if (tok_len >= w.len() || w[tok_len] != c) kw_live[k] = 1'b0;
      end
   endfunction

   function automatic void grow_token();
      if (tok_len < MAX_TOKEN_LEN) tok_len = tok_len + 8'd1;
   endfunction

   function automatic void flush_word();
      logic [2:0] kw;
      string      w;
      kw = KW_NONE;
      for (int k = 0; k < NUM_KW; k++) begin
         w = kw_word(k);
         if (kw == KW_NONE && kw_live[k] && tok_len == w.len()) kw = 3'(k + 1);
      end
      queue_token(kw != KW_NONE ? KIND_STMT : KIND_ID, tok_start, tok_len, kw, 8'd0);
   endfunction

   // Byte seen between tokens, or the byte that just closed a run.
   function automatic void fresh_byte(input logic [7:0] c);
      logic [4:0] pk;
      pk = punct_code(c);
      lex_mode = MODE_IDLE;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
         // separator, dropped
      end else if (digit(c)) begin
         lex_mode  = MODE_NUM;
         tok_start = lex_pos;
         tok_len   = 8'd1;
      end else if (letter(c)) begin
         lex_mode  = MODE_ID;
         tok_start = lex_pos;
         tok_len   = 8'd0;
         kw_live   = KW_ALL;
         kw_track(c);
         tok_len   = 8'd1;
      end else if (c == CH_HASH) begin
         lex_mode = MODE_COMMENT;
      end else if (c == CH_QUOTE) begin
         // string text starts after the opening quote
         lex_mode  = MODE_STR;
         tok_start = lex_pos + 32'd1;
         tok_len   = 8'd0;
      end else if (pk != KIND_NONE) begin
         queue_token(pk, lex_pos, 8'd1, KW_NONE, 8'd0);
      end else begin
         queue_token(KIND_ERR, lex_pos, 8'd1, KW_NONE, c);
         lex_mode = MODE_HALT;
      end
   endfunction

   // Predict the tokens caused by one accepted transaction.
   function automatic void lex_byte(input req_type item);
      logic [7:0] c;
      bit         eoi;
      int         before_n;
      rsp_type    t;
      c        = item.ch;
      eoi      = item.end_of_input || c == CH_NUL;
      before_n = due_tokens.size();
      if (eoi) begin
         // flush what is pending, then newline and EOF, then back to reset
         case (lex_mode)
            MODE_NUM: queue_token(KIND_INT, tok_start, tok_len, KW_NONE, 8'd0);
            MODE_ID:  flush_word();
            MODE_STR: queue_token(KIND_ERR, tok_start, tok_len, KW_NONE, CH_QUOTE);
            default:  ;
         endcase
         queue_token(KIND_NEWLINE, lex_pos, 8'd1, KW_NONE, 8'd0);
         queue_token(KIND_EOF, lex_pos, 8'd0, KW_NONE, 8'd0);
         lex_mode  = MODE_IDLE;
         lex_pos   = '0;
         tok_start = '0;
         tok_len   = '0;
         kw_live   = KW_ALL;
      end else begin
         case (lex_mode)
            MODE_NUM: begin
               if (digit(c)) begin
                  grow_token();
               end else begin
                  queue_token(KIND_INT, tok_start, tok_len, KW_NONE, 8'd0);
                  fresh_byte(c);
               end
            end
            MODE_ID: begin
               if (digit(c) || letter(c)) begin
                  kw_track(c);
                  grow_token();
               end else begin
                  flush_word();
                  fresh_byte(c);
               end
            end
            MODE_STR: begin
               if (c == CH_QUOTE) begin
                  queue_token(KIND_STR, tok_start, tok_len, KW_NONE, 8'd0);
                  lex_mode = MODE_IDLE;
               end else begin
                  grow_token();
               end
            end
            MODE_COMMENT: begin
               // the newline that ends a comment is still a token
               if (c == CH_NL) begin
                  queue_token(KIND_NEWLINE, lex_pos, 8'd1, KW_NONE, 8'd0);
                  lex_mode = MODE_IDLE;
               end
            end
            MODE_HALT: ;
            default: fresh_byte(c);
         endcase
         lex_pos = lex_pos + 32'd1;
      end
      if (due_tokens.size() > before_n) begin
         t      = due_tokens.pop_back();
         t.last = 1'b1;
         due_tokens.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender: one transaction per call, valid held until accepted
   // ------------------------------------------------------------------

   task automatic send_item(input logic [7:0] c, input logic eoi);
      req_type item;
      item.ch           = c;
      item.end_of_input = eoi;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // bytes swallowed after an error do not count toward the random budget
      if (lex_mode != MODE_HALT || eoi || c == CH_NUL) live_items++;
      lex_byte(item);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus a long counted hold-off on request
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_pending) begin
         hold_left    = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Every accepted token is compared with the oldest prediction.
   always @(posedge clock) begin : check_tokens
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
               $display("unexpected token: kind %0d pos %0d len %0d kw %0d bad %h last %b",
                        rsp_data.kind, rsp_data.start_pos, rsp_data.length,
                        rsp_data.keyword, rsp_data.bad_char, rsp_data.last);
         end else begin
            want = due_tokens.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.start_pos !== want.start_pos ||
                rsp_data.length !== want.length || rsp_data.keyword !== want.keyword ||
                rsp_data.bad_char !== want.bad_char || rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= SHOWN_FAILS) begin
                  $display("token mismatch at %0t", $realtime);
                  $display("  exp kind %0d pos %0d len %0d kw %0d bad %h last %b",
                           want.kind, want.start_pos, want.length, want.keyword,
                           want.bad_char, want.last);
                  $display("  got kind %0d pos %0d len %0d kw %0d bad %h last %b",
                           rsp_data.kind, rsp_data.start_pos, rsp_data.length,
                           rsp_data.keyword, rsp_data.bad_char, rsp_data.last);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Random source text
   // ------------------------------------------------------------------

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(61);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("a" + r - 10);
      return 8'("A" + r - 36);
   endfunction

   function automatic logic [7:0] punct_byte(input int i);
      case (i)
         0:       return "=";
         1:       return ">";
         2:       return "<";
         3:       return "+";
         4:       return "-";
         5:       return "*";
         6:       return "/";
         7:       return CH_NL;
         8:       return "(";
         9:       return ")";
         10:      return "[";
         11:      return "]";
         12:      return "{";
         13:      return "}";
         14:      return ",";
         default: return ":";
      endcase
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_CR;
      endcase
   endfunction

   // any byte but NUL and the given terminator
   function automatic logic [7:0] rand_body(input logic [7:0] stop);
      logic [7:0] c;
      do c = 8'($urandom_range(255, 1)); while (c == stop);
      return c;
   endfunction

   task automatic random_token();
      int    pick;
      int    n;
      string w;
      pick = $urandom_range(99);
      if (pick < 12) begin
         // keywords, with near misses: clipped or extended spellings
         w = kw_word($urandom_range(NUM_KW - 1));
         n = w.len();
         if ($urandom_range(4) == 0) n--;
         for (int i = 0; i < n; i++) send_item(w[i], 1'b0);
         if ($urandom_range(4) == 0) send_item(rand_alnum(), 1'b0);
         if ($urandom_range(3) != 0) send_item(rand_space(), 1'b0);
      end else if (pick < 26) begin
         send_item(8'("a" + $urandom_range(25)), 1'b0);
         repeat ($urandom_range(6)) send_item(rand_alnum(), 1'b0);
         if ($urandom_range(3) != 0) send_item(rand_space(), 1'b0);
      end else if (pick < 38) begin
         repeat ($urandom_range(5, 1)) send_item(8'("0" + $urandom_range(9)), 1'b0);
         if ($urandom_range(3) != 0) send_item(rand_space(), 1'b0);
      end else if (pick < 48) begin
         send_item(CH_QUOTE, 1'b0);
         repeat ($urandom_range(6)) send_item(rand_body(CH_QUOTE), 1'b0);
         // mostly closed; sometimes cut off by the end marker or a NUL
         n = $urandom_range(19);
         if (n < 17) send_item(CH_QUOTE, 1'b0);
         else if (n < 19) send_item(8'($urandom_range(255)), 1'b1);
         else send_item(CH_NUL, 1'b0);
      end else if (pick < 53) begin
         send_item(CH_HASH, 1'b0);
         repeat ($urandom_range(5)) send_item(rand_body(CH_NL), 1'b0);
         if ($urandom_range(9) != 0) send_item(CH_NL, 1'b0);
         else send_item(8'($urandom_range(255)), 1'b1);
      end else if (pick < 73) begin
         send_item(punct_byte($urandom_range(15)), 1'b0);
      end else if (pick < 86) begin
         send_item(rand_space(), 1'b0);
      end else if (pick < 94) begin
         if ($urandom_range(1)) send_item(8'($urandom_range(255)), 1'b1);
         else send_item(CH_NUL, 1'b0);
      end else begin
         // noise: any byte, often an error that halts until the end marker
         send_item(8'($urandom_range(255)), 1'b0);
         if (lex_mode == MODE_HALT && $urandom_range(1)) begin
            repeat ($urandom_range(3)) send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   task automatic run_random(input int n, input int idle_pct, input int stall_p);
      int target;
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      target        = live_items + n;
      while (live_items < target) random_token();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // keyword, integer run cut by a letter, empty string, pending id at the end
   task automatic test_statement_runs();
      send_text("if 7x=\"\"y");
      send_item(8'hFF, 1'b1);
   endtask

   // string still open when a NUL byte ends the source
   task automatic test_open_string();
      send_text("\"q");
      send_item(CH_NUL, 1'b0);
   endtask

   // comment ends in a newline token; a second comment is open at the end
   task automatic test_comment();
      send_text("#c\n#");
      send_item(8'h00, 1'b1);
   endtask

   // bad byte halts the lexer; later bytes are ignored until the end marker
   task automatic test_bad_byte();
      send_text("=");
      send_item(8'hFF, 1'b0);
      send_text("a");
      send_item(8'h7F, 1'b1);
   endtask

   // identifier longer than the length counter: length saturates, no keyword
   task automatic test_long_token();
      send_text("return");
      repeat (250) send_item(rand_alnum(), 1'b0);
      send_item(CH_SPACE, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   // receiver holds off while the sender keeps offering; the queue fills and
   // req_stall has to rise
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_pending  = 1'b1;
      send_text("1,a:(b)[c]{d}<e>f=g+h-i*j/k\n");
      send_item(8'h00, 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_statement_runs();
      test_open_string();
      test_comment();
      test_bad_byte();
      test_long_token();
      test_backpressure();

      // random source text under each idling pattern
      run_random(25, 0, 0);
      run_random(25, 51, 0);
      run_random(25, 0, 51);
      run_random(25, 21, 21);

      req_valid <= 1'b0;
      while (due_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
